/* hdl/tsa_pkg.sv */
`timescale 1ns / 1ps

package tsa_pkg;

	// default counter width
	localparam int COUNT_WIDTH_DEF = 64;

	// counter bank layout
	localparam int NUM_COUNTERS    = 24;
	localparam int NUM_BASIC       = 15;
	localparam int IDX_WIDTH       = 5;

	localparam int C_STARTED       = 0;
	localparam int C_DONE          = 1;
	localparam int C_SUCCESS       = 2;
	localparam int C_FAIL          = 3;
	localparam int C_FAIL_CONNECT  = 4;
	localparam int C_FAIL_IO       = 5;
	localparam int C_FAIL_PROTO    = 6;
	localparam int C_FAIL_RESOURCE = 7;
	localparam int C_DEFERRED      = 8;
	localparam int C_BYTES_TX      = 9;
	localparam int C_BYTES_RX      = 10;
	localparam int C_HTTP          = 11;
	localparam int C_CONCURRENCY   = 12;
	localparam int C_CONN_CREATED  = 13;
	localparam int C_CONN_REUSED   = 14;
	localparam int C_CONNECT_BASE  = 15;
	localparam int C_FIRST_RX_BASE = 18;
	localparam int C_COMPLETE_BASE = 21;

	// request kinds carried on tuser
	typedef enum logic [2:0] {
		REQ_ADMITTED   = 3'd0,
		REQ_CONN_NEW   = 3'd1,
		REQ_CONN_REUSE = 3'd2,
		REQ_START_FAIL = 3'd3,
		REQ_DEFERRED   = 3'd4,
		REQ_FINISHED   = 3'd5,
		REQ_READ       = 3'd6
	} req_type_t;

	// result codes of a finished flow
	localparam logic [2:0] RC_SUCCESS  = 3'd0;
	localparam logic [2:0] RC_CONNECT  = 3'd1;
	localparam logic [2:0] RC_PROTOCOL = 3'd2;
	localparam logic [2:0] RC_RESOURCE = 3'd3;
	localparam logic [2:0] RC_IO_FIRST = 3'd4;
	localparam logic [2:0] RC_IO_LAST  = 3'd7;

	// request payload layout
	localparam int IN_TDATA_WIDTH  = 336;
	localparam int OUT_TDATA_WIDTH = 64;

endpackage

/* hdl/transaction_stats_accumulator_core.sv */
`timescale 1ns / 1ps

// Transaction statistics accumulator: 24 cumulative counters fed by events.
// Requests enter on the s_axis channel: tuser holds the request kind
// (admitted, connection created, connection reused, start failure, deferred,
// finished, read) and tdata the timestamps, byte counts, result code, http
// flag and counter index. Only a read request produces a response on the
// m_axis channel, carrying the selected counter zero-extended to 64 bits
// (index 24..31 reads as zero).
// A request is registered on acceptance; when it leaves the input register
// the bank updates and a read response is loaded into the output register,
// whose valid flag drives tvalid.
// Throughput: one request per cycle, but for reads held by a stalled response.
// Latency differences are formed before the input register and the counter
// adds/max compares after it: each update is one add-and-compare step.
// A read reads the bank after all earlier requests have updated it.
// Reset clears every counter and the valid flags of both channel registers.
// When the receiver stalls, one response waits in the output register while
// non-read requests keep flowing; a further read holds in the input register
// and back-pressures s_axis_tready until the response is taken.
module transaction_stats_accumulator_core #(
	parameter int COUNT_WIDTH = tsa_pkg::COUNT_WIDTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	// now_time, start_time, connected_time, first_rx_time, request_bytes,
	// rsp_bytes, result_code, is_http, counter_index, zero pad
	input  logic [tsa_pkg::IN_TDATA_WIDTH-1:0]   s_axis_tdata,
	// req_type
	input  logic [2:0]                           s_axis_tuser,
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// read_value
	output logic [tsa_pkg::OUT_TDATA_WIDTH-1:0]  m_axis_tdata
);
	import tsa_pkg::*;

	// request fields
	logic [63:0]          now_time;
	logic [63:0]          start_time;
	logic [63:0]          connected_time;
	logic [63:0]          first_rx_time;
	logic [31:0]          request_bytes;
	logic [31:0]          rsp_bytes;
	logic [2:0]           result_code;
	logic                 is_http;
	logic [IDX_WIDTH-1:0] counter_index;

	assign now_time       = s_axis_tdata[63:0];
	assign start_time     = s_axis_tdata[127:64];
	assign connected_time = s_axis_tdata[191:128];
	assign first_rx_time  = s_axis_tdata[255:192];
	assign request_bytes  = s_axis_tdata[287:256];
	assign rsp_bytes      = s_axis_tdata[319:288];
	assign result_code    = s_axis_tdata[322:320];
	assign is_http        = s_axis_tdata[323];
	assign counter_index  = s_axis_tdata[328:324];

	// latency qualification and differences ahead of the input register
	logic                   cpl_ok, con_ok, frx_ok;
	logic [COUNT_WIDTH-1:0] cpl_el, con_el, frx_el;
	logic [63:0]            cpl_diff, con_diff, frx_diff;

	always_comb begin
		cpl_diff = now_time - start_time;
		con_diff = connected_time - start_time;
		frx_diff = first_rx_time - start_time;
		cpl_el   = cpl_diff[COUNT_WIDTH-1:0];
		con_el   = con_diff[COUNT_WIDTH-1:0];
		frx_el   = frx_diff[COUNT_WIDTH-1:0];
		cpl_ok   = (start_time != 64'd0) && (now_time >= start_time);
		con_ok   = (start_time != 64'd0) && (connected_time >= start_time);
		frx_ok   = (start_time != 64'd0) && (first_rx_time >= start_time);
	end

	// input register
	logic                   valid_s1;
	req_type_t              type_s1;
	logic                   cpl_ok_s1, con_ok_s1, frx_ok_s1;
	logic [COUNT_WIDTH-1:0] cpl_el_s1, con_el_s1, frx_el_s1;
	logic [31:0]            req_bytes_s1, rsp_bytes_s1;
	logic [2:0]             code_s1;
	logic                   http_s1;
	logic [IDX_WIDTH-1:0]   idx_s1;
	logic                   fire_s1;
	logic                   out_valid_q;
	logic [63:0]            out_data_q;

	assign fire_s1       = valid_s1 && ((type_s1 != REQ_READ) || !out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || fire_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			type_s1      <= req_type_t'(s_axis_tuser);
			cpl_ok_s1    <= cpl_ok;
			con_ok_s1    <= con_ok;
			frx_ok_s1    <= frx_ok;
			cpl_el_s1    <= cpl_el;
			con_el_s1    <= con_el;
			frx_el_s1    <= frx_el;
			req_bytes_s1 <= request_bytes;
			rsp_bytes_s1 <= rsp_bytes;
			code_s1      <= result_code;
			http_s1      <= is_http;
			idx_s1       <= counter_index;
		end
	end

	// event counters
	logic [COUNT_WIDTH-1:0] bank_q [NUM_BASIC];
	logic [COUNT_WIDTH-1:0] bank_d [NUM_BASIC];

	always_comb begin
		bank_d = bank_q;
		case (type_s1)
			REQ_ADMITTED: begin
				bank_d[C_STARTED]     = bank_q[C_STARTED] + COUNT_WIDTH'(1);
				bank_d[C_CONCURRENCY] = bank_q[C_CONCURRENCY] + COUNT_WIDTH'(1);
			end
			REQ_CONN_NEW: begin
				bank_d[C_CONN_CREATED] = bank_q[C_CONN_CREATED] + COUNT_WIDTH'(1);
			end
			REQ_CONN_REUSE: begin
				bank_d[C_CONN_REUSED] = bank_q[C_CONN_REUSED] + COUNT_WIDTH'(1);
			end
			REQ_START_FAIL: begin
				bank_d[C_STARTED]      = bank_q[C_STARTED] + COUNT_WIDTH'(1);
				bank_d[C_DONE]         = bank_q[C_DONE] + COUNT_WIDTH'(1);
				bank_d[C_FAIL]         = bank_q[C_FAIL] + COUNT_WIDTH'(1);
				bank_d[C_FAIL_CONNECT] = bank_q[C_FAIL_CONNECT] + COUNT_WIDTH'(1);
			end
			REQ_DEFERRED: begin
				bank_d[C_DEFERRED] = bank_q[C_DEFERRED] + COUNT_WIDTH'(1);
			end
			REQ_FINISHED: begin
				bank_d[C_DONE]     = bank_q[C_DONE] + COUNT_WIDTH'(1);
				bank_d[C_BYTES_TX] = bank_q[C_BYTES_TX] + COUNT_WIDTH'(req_bytes_s1);
				bank_d[C_BYTES_RX] = bank_q[C_BYTES_RX] + COUNT_WIDTH'(rsp_bytes_s1);
				// concurrency gauge stops at zero
				if (bank_q[C_CONCURRENCY] != '0) begin
					bank_d[C_CONCURRENCY] = bank_q[C_CONCURRENCY] - COUNT_WIDTH'(1);
				end
				// outcome classification
				case (code_s1) inside
					RC_SUCCESS: begin
						bank_d[C_SUCCESS] = bank_q[C_SUCCESS] + COUNT_WIDTH'(1);
						if (http_s1) begin
							bank_d[C_HTTP] = bank_q[C_HTTP] + COUNT_WIDTH'(1);
						end
					end
					RC_CONNECT: begin
						bank_d[C_FAIL]         = bank_q[C_FAIL] + COUNT_WIDTH'(1);
						bank_d[C_FAIL_CONNECT] = bank_q[C_FAIL_CONNECT] + COUNT_WIDTH'(1);
					end
					RC_PROTOCOL: begin
						bank_d[C_FAIL]       = bank_q[C_FAIL] + COUNT_WIDTH'(1);
						bank_d[C_FAIL_PROTO] = bank_q[C_FAIL_PROTO] + COUNT_WIDTH'(1);
					end
					RC_RESOURCE: begin
						bank_d[C_FAIL]          = bank_q[C_FAIL] + COUNT_WIDTH'(1);
						bank_d[C_FAIL_RESOURCE] = bank_q[C_FAIL_RESOURCE] + COUNT_WIDTH'(1);
					end
					[RC_IO_FIRST:RC_IO_LAST]: begin
						bank_d[C_FAIL]    = bank_q[C_FAIL] + COUNT_WIDTH'(1);
						bank_d[C_FAIL_IO] = bank_q[C_FAIL_IO] + COUNT_WIDTH'(1);
					end
					default: begin
					end
				endcase
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_BASIC; i++) begin
				bank_q[i] <= '0;
			end
		end else if (fire_s1) begin
			bank_q <= bank_d;
		end
	end

	// latency statistics
	logic                   fin_s1;
	logic [COUNT_WIDTH-1:0] con_samples, con_total, con_peak;
	logic [COUNT_WIDTH-1:0] frx_samples, frx_total, frx_peak;
	logic [COUNT_WIDTH-1:0] cpl_samples, cpl_total, cpl_peak;

	assign fin_s1 = fire_s1 && (type_s1 == REQ_FINISHED);

	tsa_latency #(.COUNT_WIDTH(COUNT_WIDTH)) u_connect (
		.clk     (clk),
		.arst_n  (arst_n),
		.upd     (fin_s1 && con_ok_s1),
		.elapsed (con_el_s1),
		.samples (con_samples),
		.total   (con_total),
		.peak    (con_peak)
	);

	tsa_latency #(.COUNT_WIDTH(COUNT_WIDTH)) u_first_rx (
		.clk     (clk),
		.arst_n  (arst_n),
		.upd     (fin_s1 && frx_ok_s1),
		.elapsed (frx_el_s1),
		.samples (frx_samples),
		.total   (frx_total),
		.peak    (frx_peak)
	);

	tsa_latency #(.COUNT_WIDTH(COUNT_WIDTH)) u_complete (
		.clk     (clk),
		.arst_n  (arst_n),
		.upd     (fin_s1 && cpl_ok_s1),
		.elapsed (cpl_el_s1),
		.samples (cpl_samples),
		.total   (cpl_total),
		.peak    (cpl_peak)
	);

	// read selection over the whole bank
	logic [COUNT_WIDTH-1:0] view [NUM_COUNTERS];
	logic [63:0]            rd_value;

	always_comb begin
		for (int i = 0; i < NUM_BASIC; i++) begin
			view[i] = bank_q[i];
		end
		view[C_CONNECT_BASE]      = con_samples;
		view[C_CONNECT_BASE + 1]  = con_total;
		view[C_CONNECT_BASE + 2]  = con_peak;
		view[C_FIRST_RX_BASE]     = frx_samples;
		view[C_FIRST_RX_BASE + 1] = frx_total;
		view[C_FIRST_RX_BASE + 2] = frx_peak;
		view[C_COMPLETE_BASE]     = cpl_samples;
		view[C_COMPLETE_BASE + 1] = cpl_total;
		view[C_COMPLETE_BASE + 2] = cpl_peak;
		if (idx_s1 < IDX_WIDTH'(NUM_COUNTERS)) begin
			rd_value = 64'(view[idx_s1]);
		end else begin
			rd_value = 64'd0;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_s1 && (type_s1 == REQ_READ)) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && (type_s1 == REQ_READ)) begin
			out_data_q <= rd_value;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule

/* hdl/tsa_latency.sv */
`timescale 1ns / 1ps

module tsa_latency #(
	parameter int COUNT_WIDTH = tsa_pkg::COUNT_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   upd,
	input  logic [COUNT_WIDTH-1:0] elapsed,
	output logic [COUNT_WIDTH-1:0] samples,
	output logic [COUNT_WIDTH-1:0] total,
	output logic [COUNT_WIDTH-1:0] peak
);
	import tsa_pkg::*;

	logic [COUNT_WIDTH-1:0] samples_q;
	logic [COUNT_WIDTH-1:0] total_q;
	logic [COUNT_WIDTH-1:0] peak_q;

	// sample count, running sum and maximum of one latency
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			samples_q <= '0;
			total_q   <= '0;
			peak_q    <= '0;
		end else if (upd) begin
			samples_q <= samples_q + COUNT_WIDTH'(1);
			total_q   <= total_q + elapsed;
			if (elapsed > peak_q) begin
				peak_q <= elapsed;
			end
		end
	end

	assign samples = samples_q;
	assign total   = total_q;
	assign peak    = peak_q;

endmodule

/* tb/sv/tb_transaction_stats_accumulator_core.sv */
`timescale 1ns / 1ps

module tb_transaction_stats_accumulator_core;
	import tsa_pkg::*;

	localparam int CLK_PERIOD   = 20;
	localparam int RESET_CYCLES = 9;
	localparam int RANDOM_ITEMS = 1500;
	localparam int HOLD_AT      = 300;
	localparam int HOLD_CYCLES  = 300;
	localparam int CALM_LO      = 800;
	localparam int CALM_HI      = 1100;
	localparam int STALL_LIMIT  = 3000;
	localparam int DRAIN_CYCLES = 10;
	localparam int PROBE_ROWS   = 24;

	// request kind left unused by the block
	localparam logic [2:0]  REQ_UNUSED = 3'd7;
	localparam logic [63:0] TMAX       = '1;
	localparam logic [31:0] BMAX       = '1;
	localparam logic [4:0]  IDX_TOP    = '1;

	// one request as the block sees it
	typedef struct packed {
		logic [2:0]  kind;
		logic [63:0] now_t;
		logic [63:0] start_t;
		logic [63:0] conn_t;
		logic [63:0] frx_t;
		logic [31:0] tx_bytes;
		logic [31:0] rx_bytes;
		logic [2:0]  rc;
		logic        http;
		logic [4:0]  idx;
	} flow_req_t;

	// directed row: request plus a typed-in read value where obvious
	typedef struct {
		flow_req_t   req;
		bit          pinned;
		logic [63:0] pinned_val;
	} probe_row_t;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        s_axis_tvalid = 1'b0;
	logic                        s_axis_tready;
	logic [IN_TDATA_WIDTH-1:0]   s_axis_tdata = '0;
	logic [2:0]                  s_axis_tuser = '0;
	logic                        m_axis_tvalid;
	logic                        m_axis_tready = 1'b0;
	logic [OUT_TDATA_WIDTH-1:0]  m_axis_tdata;

	// predicted counter bank and read values still owed by the block
	logic [63:0] stat_bank [NUM_COUNTERS];
	logic [63:0] pending_reads [$];
	logic [63:0] want_val;
	int          err_cnt = 0;
	int          sent_cnt = 0;
	int          idle_cycles = 0;

	probe_row_t probe_rows [PROBE_ROWS] = '{
		// reads right after reset
		'{'{REQ_READ, 64'd0, 64'd0, 64'd0, 64'd0, 32'd0, 32'd0, RC_SUCCESS, 1'b0,
			5'(C_STARTED)}, 1'b1, 64'd0},
		'{'{REQ_READ, 64'd0, 64'd0, 64'd0, 64'd0, 32'd0, 32'd0, RC_SUCCESS, 1'b0,
			5'(C_COMPLETE_BASE + 2)}, 1'b1, 64'd0},
		'{'{REQ_READ, 64'd0, 64'd0, 64'd0, 64'd0, 32'd0, 32'd0, RC_SUCCESS, 1'b0,
			IDX_TOP}, 1'b1, 64'd0},
		// finish at zero concurrency, unknown start time
		'{'{REQ_FINISHED, TMAX, 64'd0, TMAX, TMAX, 32'd0, 32'd0, RC_SUCCESS, 1'b1,
			5'd0}, 1'b0, 64'd0},
		'{'{REQ_READ, 64'd0, 64'd0, 64'd0, 64'd0, 32'd0, 32'd0, RC_SUCCESS, 1'b0,
			5'(C_CONCURRENCY)}, 1'b1, 64'd0},
		// every plain event kind
		'{'{REQ_ADMITTED, 64'd0, 64'd0, 64'd0, 64'd0, 32'd0, 32'd0, RC_SUCCESS, 1'b0,
			5'd0}, 1'b0, 64'd0},
		'{'{REQ_ADMITTED, TMAX, TMAX, TMAX, TMAX, BMAX, BMAX, RC_IO_LAST, 1'b1,
			IDX_TOP}, 1'b0, 64'd0},
		'{'{REQ_CONN_NEW, 64'd0, 64'd0, 64'd0, 64'd0, 32'd0, 32'd0, RC_SUCCESS, 1'b0,
			5'd0}, 1'b0, 64'd0},
		'{'{REQ_CONN_REUSE, 64'd0, 64'd0, 64'd0, 64'd0, 32'd0, 32'd0, RC_SUCCESS, 1'b0,
			5'd0}, 1'b0, 64'd0},
		'{'{REQ_START_FAIL, 64'd0, 64'd0, 64'd0, 64'd0, 32'd0, 32'd0, RC_SUCCESS, 1'b0,
			5'd0}, 1'b0, 64'd0},
		'{'{REQ_DEFERRED, 64'd0, 64'd0, 64'd0, 64'd0, 32'd0, 32'd0, RC_SUCCESS, 1'b0,
			5'd0}, 1'b0, 64'd0},
		'{'{REQ_UNUSED, TMAX, 64'd1, TMAX, TMAX, BMAX, BMAX, RC_SUCCESS, 1'b1,
			5'd0}, 1'b0, 64'd0},
		// finishes: widest latencies and byte counts
		'{'{REQ_FINISHED, TMAX, 64'd1, TMAX, TMAX, BMAX, BMAX, RC_CONNECT, 1'b0,
			5'd0}, 1'b0, 64'd0},
		// later time below start, and equal to start
		'{'{REQ_FINISHED, 64'd5, TMAX, TMAX, 64'd0, BMAX, 32'd0, RC_PROTOCOL, 1'b1,
			5'd0}, 1'b0, 64'd0},
		'{'{REQ_FINISHED, 64'd100, 64'd100, 64'd99, 64'd150, 32'd0, BMAX, RC_RESOURCE,
			1'b0, 5'd0}, 1'b0, 64'd0},
		'{'{REQ_FINISHED, 64'd20, 64'd10, 64'd15, 64'd12, 32'd7, 32'd9, RC_IO_FIRST, 1'b0,
			5'd0}, 1'b0, 64'd0},
		'{'{REQ_FINISHED, 64'd30, 64'd10, 64'd11, 64'd25, 32'd1, 32'd2, RC_IO_LAST, 1'b1,
			5'd0}, 1'b0, 64'd0},
		'{'{REQ_FINISHED, 64'd6, 64'd5, 64'd5, 64'd6, 32'd3, 32'd4, RC_SUCCESS, 1'b0,
			5'd0}, 1'b0, 64'd0},
		// reads checked against the predictor; the last, out of range, pinned to zero
		'{'{REQ_READ, 64'd0, 64'd0, 64'd0, 64'd0, 32'd0, 32'd0, RC_SUCCESS, 1'b0,
			5'(C_CONCURRENCY)}, 1'b0, 64'd0},
		'{'{REQ_READ, 64'd0, 64'd0, 64'd0, 64'd0, 32'd0, 32'd0, RC_SUCCESS, 1'b0,
			5'(C_COMPLETE_BASE + 1)}, 1'b0, 64'd0},
		'{'{REQ_READ, 64'd0, 64'd0, 64'd0, 64'd0, 32'd0, 32'd0, RC_SUCCESS, 1'b0,
			5'(C_COMPLETE_BASE + 2)}, 1'b0, 64'd0},
		'{'{REQ_READ, 64'd0, 64'd0, 64'd0, 64'd0, 32'd0, 32'd0, RC_SUCCESS, 1'b0,
			5'(C_BYTES_TX)}, 1'b0, 64'd0},
		'{'{REQ_READ, 64'd0, 64'd0, 64'd0, 64'd0, 32'd0, 32'd0, RC_SUCCESS, 1'b0,
			5'(C_FAIL_IO)}, 1'b0, 64'd0},
		'{'{REQ_READ, TMAX, TMAX, TMAX, TMAX, BMAX, BMAX, RC_IO_LAST, 1'b1,
			5'(NUM_COUNTERS)}, 1'b1, 64'd0}
	};

	transaction_stats_accumulator_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic bit calm_window();
		return sent_cnt >= CALM_LO && sent_cnt < CALM_HI;
	endfunction

	// counter bump, wraps at 64 bits
	function automatic void bump_stat(int c, logic [63:0] amt);
		stat_bank[c] = stat_bank[c] + amt;
	endfunction

	// samples, sum and max of one latency
	function automatic void note_latency(int base, logic [63:0] start_t, logic [63:0] later_t);
		logic [63:0] span;
		if (start_t == 64'd0 || later_t < start_t)
			return;
		span = later_t - start_t;
		bump_stat(base, 64'd1);
		bump_stat(base + 1, span);
		if (span > stat_bank[base + 2])
			stat_bank[base + 2] = span;
	endfunction

	// apply one request to the predicted bank; returns 1 for a read
	function automatic bit tally_request(flow_req_t r, output logic [63:0] rd);
		rd = 64'd0;
		case (r.kind)
			REQ_ADMITTED: begin
				bump_stat(C_STARTED, 64'd1);
				bump_stat(C_CONCURRENCY, 64'd1);
			end
			REQ_CONN_NEW:   bump_stat(C_CONN_CREATED, 64'd1);
			REQ_CONN_REUSE: bump_stat(C_CONN_REUSED, 64'd1);
			REQ_START_FAIL: begin
				bump_stat(C_STARTED, 64'd1);
				bump_stat(C_DONE, 64'd1);
				bump_stat(C_FAIL, 64'd1);
				bump_stat(C_FAIL_CONNECT, 64'd1);
			end
			REQ_DEFERRED: bump_stat(C_DEFERRED, 64'd1);
			REQ_FINISHED: begin
				note_latency(C_COMPLETE_BASE, r.start_t, r.now_t);
				note_latency(C_CONNECT_BASE, r.start_t, r.conn_t);
				note_latency(C_FIRST_RX_BASE, r.start_t, r.frx_t);
				bump_stat(C_DONE, 64'd1);
				// concurrency stops at zero
				if (stat_bank[C_CONCURRENCY] != 64'd0)
					stat_bank[C_CONCURRENCY] = stat_bank[C_CONCURRENCY] - 64'd1;
				bump_stat(C_BYTES_TX, {32'd0, r.tx_bytes});
				bump_stat(C_BYTES_RX, {32'd0, r.rx_bytes});
				if (r.rc == RC_SUCCESS) begin
					bump_stat(C_SUCCESS, 64'd1);
					if (r.http)
						bump_stat(C_HTTP, 64'd1);
				end else begin
					bump_stat(C_FAIL, 64'd1);
					case (r.rc)
						RC_CONNECT:  bump_stat(C_FAIL_CONNECT, 64'd1);
						RC_PROTOCOL: bump_stat(C_FAIL_PROTO, 64'd1);
						RC_RESOURCE: bump_stat(C_FAIL_RESOURCE, 64'd1);
						default:     bump_stat(C_FAIL_IO, 64'd1);
					endcase
				end
			end
			REQ_READ: begin
				if (r.idx < NUM_COUNTERS)
					rd = stat_bank[r.idx];
				return 1'b1;
			end
			default: ;
		endcase
		return 1'b0;
	endfunction

	// later timestamp: mostly a sane delta after start, sometimes below or wild
	function automatic logic [63:0] later_stamp(logic [63:0] start_t);
		int sel;
		sel = $urandom_range(99);
		if (sel < 10)
			return start_t - 64'($urandom_range(1000));
		if (sel < 20)
			return rand64();
		if (sel < 75)
			return start_t + 64'($urandom_range(5000));
		return start_t + (rand64() >> $urandom_range(63));
	endfunction

	// offer one request, wait for it to be taken, then predict
	task automatic offer_request(flow_req_t r, bit pinned, logic [63:0] pinned_val);
		logic [63:0] rd;
		while (!calm_window() && $urandom_range(99) < 9) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= r.kind;
		// 7 bits of zero pad above counter_index
		s_axis_tdata  <= {7'd0, r.idx, r.http, r.rc, r.rx_bytes, r.tx_bytes,
			r.frx_t, r.conn_t, r.start_t, r.now_t};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		sent_cnt++;
		if (tally_request(r, rd))
			pending_reads.push_back(pinned ? pinned_val : rd);
	endtask

	// random request with shaped timestamps for finishes
	task automatic offer_random();
		flow_req_t r;
		int        sel;
		r.now_t    = rand64();
		r.start_t  = rand64();
		r.conn_t   = rand64();
		r.frx_t    = rand64();
		r.tx_bytes = $urandom;
		r.rx_bytes = $urandom;
		r.rc       = 3'($urandom_range(7));
		r.http     = 1'($urandom_range(1));
		r.idx      = 5'($urandom_range(31));
		sel = $urandom_range(99);
		if (sel < 18)      r.kind = REQ_ADMITTED;
		else if (sel < 24) r.kind = REQ_CONN_NEW;
		else if (sel < 30) r.kind = REQ_CONN_REUSE;
		else if (sel < 35) r.kind = REQ_START_FAIL;
		else if (sel < 40) r.kind = REQ_DEFERRED;
		else if (sel < 70) r.kind = REQ_FINISHED;
		else if (sel < 97) r.kind = REQ_READ;
		else               r.kind = REQ_UNUSED;
		if (r.kind == REQ_FINISHED) begin
			sel = $urandom_range(99);
			if (sel < 10)
				r.start_t = 64'd0;
			else if (sel < 70)
				r.start_t = r.start_t >> $urandom_range(63);
			r.now_t  = later_stamp(r.start_t);
			r.conn_t = later_stamp(r.start_t);
			r.frx_t  = later_stamp(r.start_t);
			if ($urandom_range(1))
				r.tx_bytes = $urandom_range(1500);
		end
		if (r.kind == REQ_READ && $urandom_range(99) < 90)
			r.idx = 5'($urandom_range(NUM_COUNTERS - 1));
		offer_request(r, 1'b0, 64'd0);
	endtask

	// response checker
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_reads.size() == 0) begin
				$display("%0t: read_value with no read pending, actual %h", $time, m_axis_tdata);
				err_cnt++;
			end else begin
				want_val = pending_reads.pop_front();
				if (m_axis_tdata !== want_val) begin
					$display("%0t: read_value mismatch, expected %h actual %h",
						$time, want_val, m_axis_tdata);
					err_cnt++;
				end
			end
		end
	end

	// watchdog on cycles with no request or response taken
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles == STALL_LIMIT) begin
				$display("transaction_stats_accumulator_core regression: fail");
				$finish;
			end
		end
	end

	// response side: random stalls, one long hold-off, one calm stretch
	initial begin
		bit held;
		int hold_left;
		held = 1'b0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (!held && sent_cnt >= HOLD_AT) begin
				held = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				m_axis_tready <= 1'b0;
				hold_left--;
			end else if (calm_window()) begin
				m_axis_tready <= 1'b1;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= 9);
			end
		end
	end

	// request side
	initial begin
		flow_req_t sweep;
		for (int c = 0; c < NUM_COUNTERS; c++)
			stat_bank[c] = 64'd0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < PROBE_ROWS; i++)
			offer_request(probe_rows[i].req, probe_rows[i].pinned, probe_rows[i].pinned_val);

		for (int i = 0; i < RANDOM_ITEMS; i++)
			offer_random();

		// read back every index, in range or not
		sweep = '0;
		sweep.kind = REQ_READ;
		for (int i = 0; i <= IDX_TOP; i++) begin
			sweep.idx = 5'(i);
			offer_request(sweep, 1'b0, 64'd0);
		end
		s_axis_tvalid <= 1'b0;

		while (pending_reads.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_cnt == 0)
			$display("transaction_stats_accumulator_core regression: pass");
		else
			$display("transaction_stats_accumulator_core regression: fail");
		$finish;
	end

endmodule
